[hw/rtl/mexp_pkg.sv]
`timescale 1ns / 1ps

package mexp_pkg;

    // operand and field widths
    localparam int WORD_W = 32;
    localparam int EXP_W  = 63;

    // apb address width, one 32-bit register at byte address 0
    localparam int ADDR_W = 2;

    // register map
    localparam logic [ADDR_W-1:0] REG_MODULUS_ADDR = ADDR_W'(0);

    // modulus after reset
    localparam logic [WORD_W-1:0] MODULUS_RESET = WORD_W'(1000000007);

    // request to the shared modular multiplier
    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } t_mul_req;

    // response from the shared modular multiplier
    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] prod;
    } t_mul_rsp;

endpackage

[hw/rtl/mexp_apb_regs.sv]
`timescale 1ns / 1ps

module mexp_apb_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mexp_pkg::ADDR_W-1:0]         paddr,
    input  logic [mexp_pkg::WORD_W-1:0]         pwdata,
    output logic [mexp_pkg::WORD_W-1:0]         prdata,
    output logic                                pready,
    output logic [mexp_pkg::WORD_W-1:0]         o_modulus
);

    logic [mexp_pkg::WORD_W-1:0] r_modulus;
    logic                        w_wr;

    // write beat completes in the access phase
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    // modulus register, byte offset bits ignored on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= mexp_pkg::MODULUS_RESET;
        end else if (w_wr) begin
            r_modulus <= pwdata;
        end
    end

    // read mux
    always_comb begin
        if (paddr == mexp_pkg::REG_MODULUS_ADDR) begin
            prdata = r_modulus;
        end else begin
            prdata = '0;
        end
    end

    assign o_modulus = r_modulus;

endmodule

[hw/rtl/mexp_modmul.sv]
`timescale 1ns / 1ps

module mexp_modmul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [mexp_pkg::WORD_W-1:0] i_modulus,
    input  mexp_pkg::t_mul_req          i_req,
    output mexp_pkg::t_mul_rsp          o_rsp
);

    localparam int W     = mexp_pkg::WORD_W;
    localparam int CNT_W = $clog2(W);

    logic [W-1:0]     r_a;
    logic [W-1:0]     r_b;
    logic [W-1:0]     r_r;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [W+1:0]     w_t;
    logic [W+2:0]     w_d1;
    logic [W+2:0]     w_d2;
    logic [W-1:0]     w_step;

    // one interleaved step: r = (2r + bit*a) mod m, with r < m and a < m so t < 3m
    assign w_t  = {1'b0, r_r, 1'b0} + (r_b[W-1] ? {2'b00, r_a} : {(W+2){1'b0}});
    assign w_d1 = {1'b0, w_t} - {3'b000, i_modulus};
    assign w_d2 = {1'b0, w_t} - {2'b00, i_modulus, 1'b0};

    always_comb begin
        priority if (!w_d2[W+2]) begin
            w_step = w_d2[W-1:0];
        end else if (!w_d1[W+2]) begin
            w_step = w_d1[W-1:0];
        end else begin
            w_step = w_t[W-1:0];
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operands and partial remainder, multiplier bits taken msb first
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_req.a;
            r_b <= i_req.b;
            r_r <= '0;
        end else if (r_busy) begin
            r_b <= {r_b[W-2:0], 1'b0};
            r_r <= w_step;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_r;

endmodule

[hw/rtl/modular_exponentiation.sv]
`timescale 1ns / 1ps

// Computes base^exponent mod modulus by right-to-left square-and-multiply. Raise start
// for one cycle while busy is low; the result appears on o_power_result with o_done high
// for exactly one cycle and must be captured then, as the block cannot be stalled. All
// arithmetic goes through one shared shift-add modular multiplier: one product reduces
// the base, then each exponent bit up to the highest set one costs a squaring, plus a
// multiply for every set bit (the final squaring is skipped). Busy is already low in the
// result cycle, so the next start can be taken at that same edge. With a modulus below 2
// the result is 0 and its beat comes in the cycle after the start beat.
// The modulus register sits at byte address 0 and must only be written while busy is low.
module modular_exponentiation (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [mexp_pkg::WORD_W-1:0]         i_base_value,
    input  logic [mexp_pkg::EXP_W-1:0]          i_exponent_value,
    output logic                                o_done,
    output logic [mexp_pkg::WORD_W-1:0]         o_power_result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mexp_pkg::ADDR_W-1:0]         paddr,
    input  logic [mexp_pkg::WORD_W-1:0]         pwdata,
    output logic [mexp_pkg::WORD_W-1:0]         prdata,
    output logic                                pready
);

    localparam int W  = mexp_pkg::WORD_W;
    localparam int EW = mexp_pkg::EXP_W;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_REDUCE = 4'b0010,
        S_MUL    = 4'b0100,
        S_SQR    = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [W-1:0]        r_acc, n_acc;
    logic [W-1:0]        r_sq, n_sq;
    logic [EW-1:0]       r_exp, n_exp;
    logic [W-1:0]        r_result, n_result;
    logic                r_done, n_done;
    logic                r_mul_start, n_mul_start;
    logic [EW-1:0]       w_exp_shr;

    logic [W-1:0]        w_modulus;
    mexp_pkg::t_mul_req  w_req;
    mexp_pkg::t_mul_rsp  w_rsp;

    // configuration register
    mexp_apb_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_modulus (w_modulus)
    );

    // shared modular multiplier
    mexp_modmul u_modmul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_modulus (w_modulus),
        .i_req     (w_req),
        .o_rsp     (w_rsp)
    );

    // operand select for the multiplier
    always_comb begin
        w_req.start = r_mul_start;
        unique case (r_state)
            S_REDUCE: begin
                w_req.a = W'(1);
                w_req.b = r_sq;
            end
            S_MUL: begin
                w_req.a = r_acc;
                w_req.b = r_sq;
            end
            default: begin
                w_req.a = r_sq;
                w_req.b = r_sq;
            end
        endcase
    end

    assign w_exp_shr = r_exp >> 1;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_sq        = r_sq;
        n_exp       = r_exp;
        n_result    = r_result;
        n_done      = 1'b0;
        n_mul_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (w_modulus < W'(2)) begin
                        n_done   = 1'b1;
                        n_result = '0;
                    end else begin
                        n_sq        = i_base_value;
                        n_exp       = i_exponent_value;
                        n_acc       = W'(1);
                        n_state     = S_REDUCE;
                        n_mul_start = 1'b1;
                    end
                end
            end
            S_REDUCE: begin
                if (w_rsp.done) begin
                    n_sq = w_rsp.prod;
                    priority if (r_exp == '0) begin
                        n_done   = 1'b1;
                        n_result = r_acc;
                        n_state  = S_IDLE;
                    end else if (r_exp[0]) begin
                        n_state     = S_MUL;
                        n_mul_start = 1'b1;
                    end else begin
                        n_state     = S_SQR;
                        n_mul_start = 1'b1;
                    end
                end
            end
            S_MUL: begin
                if (w_rsp.done) begin
                    n_acc = w_rsp.prod;
                    // last set bit: the trailing square is not needed
                    if (w_exp_shr == '0) begin
                        n_done   = 1'b1;
                        n_result = w_rsp.prod;
                        n_state  = S_IDLE;
                    end else begin
                        n_state     = S_SQR;
                        n_mul_start = 1'b1;
                    end
                end
            end
            S_SQR: begin
                if (w_rsp.done) begin
                    n_sq  = w_rsp.prod;
                    n_exp = w_exp_shr;
                    priority if (w_exp_shr == '0) begin
                        n_done   = 1'b1;
                        n_result = r_acc;
                        n_state  = S_IDLE;
                    end else if (w_exp_shr[0]) begin
                        n_state     = S_MUL;
                        n_mul_start = 1'b1;
                    end else begin
                        n_state     = S_SQR;
                        n_mul_start = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_done      <= 1'b0;
            r_mul_start <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_done      <= n_done;
            r_mul_start <= n_mul_start;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_sq     <= n_sq;
        r_exp    <= n_exp;
        r_result <= n_result;
    end

    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_power_result = r_result;

    // result beat is only issued on the way back to idle or, for a modulus below 2, from idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result beat while busy");

    // multiplier only answers while an item is in flight
    a_rsp_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> busy)
        else $error("multiplier response while idle");

    // an accepted item either starts work or answers at once
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted item dropped");

    // multiplier is never started while idle
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mul_start |-> busy)
        else $error("multiplier started while idle");

endmodule

[dv/modular_exponentiation_tb.sv]
`timescale 1ns / 1ps

module modular_exponentiation_tb;

    import mexp_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 20000;
    localparam int unsigned END_DRAIN      = 50;
    localparam int unsigned IDLE_SETTLE    = 4;
    localparam int unsigned MAX_REPORTS    = 10;
    localparam int unsigned RANDOM_PER_SET = 12;

    localparam logic [EXP_W-1:0] EXP_MAX = {EXP_W{1'b1}};

    typedef struct packed {
        logic [WORD_W-1:0] base;
        logic [EXP_W-1:0]  exponent;
    } power_job_t;

    // clock, reset and block inputs, all known from time zero
    logic              i_clk            = 1'b0;
    logic              i_rst_n          = 1'b0;
    logic              start            = 1'b0;
    logic [WORD_W-1:0] i_base_value     = '0;
    logic [EXP_W-1:0]  i_exponent_value = '0;
    logic              psel             = 1'b0;
    logic              penable          = 1'b0;
    logic              pwrite           = 1'b0;
    logic [ADDR_W-1:0] paddr            = '0;
    logic [WORD_W-1:0] pwdata           = '0;

    logic              busy;
    logic              o_done;
    logic [WORD_W-1:0] o_power_result;
    logic [WORD_W-1:0] prdata;
    logic              pready;

    // jobs waiting to be issued and powers still owed by the block
    power_job_t        job_q[$];
    logic [WORD_W-1:0] power_q[$];

    power_job_t        next_job;
    int unsigned       gap_left     = 0;
    logic [WORD_W-1:0] modulus_copy = MODULUS_RESET;
    logic [WORD_W-1:0] owed_power;
    logic              beat_seen;
    int unsigned       idle_cycles  = 0;
    int unsigned       error_count  = 0;
    logic [WORD_W-1:0] modulus_plan [8];

    modular_exponentiation u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_base_value     (i_base_value),
        .i_exponent_value (i_exponent_value),
        .o_done           (o_done),
        .o_power_result   (o_power_result),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // 50 MHz clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // right-to-left square-and-multiply at 64-bit precision
    function automatic logic [WORD_W-1:0] power_mod(input logic [WORD_W-1:0] base,
                                                    input logic [EXP_W-1:0]  exponent,
                                                    input logic [WORD_W-1:0] modulus);
        logic [63:0]      acc;
        logic [63:0]      sq;
        logic [63:0]      m;
        logic [EXP_W-1:0] e;
        if (modulus < 2) begin
            return '0;
        end
        m   = {32'b0, modulus};
        acc = 64'd1;
        sq  = {32'b0, base} % m;
        e   = exponent;
        while (e != 0) begin
            if (e[0]) begin
                acc = (acc * sq) % m;
            end
            sq = (sq * sq) % m;
            e  = e >> 1;
        end
        return acc[WORD_W-1:0];
    endfunction

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int unsigned pick_gap();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return 0;
            6, 7, 8:          return $urandom_range(1, 4);
            default:          return $urandom_range(20, 200);
        endcase
    endfunction

    // bases biased towards the edges of the current modulus
    function automatic logic [WORD_W-1:0] pick_base(input logic [WORD_W-1:0] modulus);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return WORD_W'(1);
            2:       return modulus - 1;
            3:       return modulus;
            4:       return {WORD_W{1'b1}};
            default: return WORD_W'($urandom);
        endcase
    endfunction

    // short exponents dominate, a fraction spans the full width
    function automatic logic [EXP_W-1:0] pick_exponent();
        logic [63:0] raw;
        int unsigned len;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       len = EXP_W;
            1:       len = $urandom_range(17, EXP_W);
            default: len = $urandom_range(0, 16);
        endcase
        if (len < EXP_W) begin
            raw = raw & ((64'd1 << len) - 64'd1);
        end
        return raw[EXP_W-1:0];
    endfunction

    task automatic push_job(input logic [WORD_W-1:0] base, input logic [EXP_W-1:0] exponent);
        power_job_t job;
        job.base     = base;
        job.exponent = exponent;
        job_q.push_back(job);
    endtask

    // one apb transfer to the modulus register: setup, then access
    task automatic apb_access(input logic write, input logic [WORD_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= REG_MODULUS_ADDR;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // block quiet: nothing queued, nothing owed, not busy
    task automatic wait_idle();
        do begin
            @(posedge i_clk);
        end while (job_q.size() != 0 || start || busy || power_q.size() != 0);
        repeat (IDLE_SETTLE) @(posedge i_clk);
    endtask

    // a zero exponent and a squared modulus - 1, then random jobs
    task automatic queue_set(input logic [WORD_W-1:0] modulus, input int unsigned count);
        push_job(WORD_W'($urandom), '0);
        push_job(modulus - 1, EXP_W'(2));
        repeat (count) push_job(pick_base(modulus), pick_exponent());
    endtask

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] want,
                                   input logic [WORD_W-1:0] got);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("mismatch: %s expected %0d got %0d", what, want, got);
        end
    endtask

    // driver: hold a job until its beat is taken, then wait out the gap
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start    <= 1'b0;
            gap_left <= 0;
        end else if (!start || !busy) begin
            if (gap_left != 0) begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (job_q.size() != 0) begin
                next_job = job_q.pop_front();
                start            <= 1'b1;
                i_base_value     <= next_job.base;
                i_exponent_value <= next_job.exponent;
                gap_left         <= pick_gap();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: check results, predict accepted jobs, track the register, watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            beat_seen = 1'b0;
            // results first, so a job taken at the same edge is not matched
            if (o_done) begin
                beat_seen = 1'b1;
                if (power_q.size() == 0) begin
                    report_mismatch("result with no job outstanding", '0, o_power_result);
                end else begin
                    owed_power = power_q.pop_front();
                    if (o_power_result !== owed_power) begin
                        report_mismatch("power_result", owed_power, o_power_result);
                    end
                end
            end
            if (start && !busy) begin
                beat_seen = 1'b1;
                power_q.push_back(power_mod(i_base_value, i_exponent_value, modulus_copy));
            end
            if (psel && penable && pready) begin
                beat_seen = 1'b1;
                if (pwrite) begin
                    if (paddr == REG_MODULUS_ADDR) begin
                        modulus_copy = pwdata;
                    end
                end else if (prdata !== modulus_copy) begin
                    report_mismatch("modulus readback", modulus_copy, prdata);
                end
            end
            if (beat_seen) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("modular_exponentiation regression: fail");
                $finish;
            end
        end
    end

    // sequence: reset, directed jobs at the reset modulus, then one set per modulus
    initial begin
        modulus_plan[0] = WORD_W'(2);
        modulus_plan[1] = {WORD_W{1'b1}};
        modulus_plan[2] = WORD_W'(32'hFFFF_FFFB);
        modulus_plan[3] = WORD_W'($urandom_range(32'hFFFF_FFFF, 2));
        modulus_plan[4] = WORD_W'(1);
        modulus_plan[5] = '0;
        modulus_plan[6] = WORD_W'($urandom_range(1000, 3));
        modulus_plan[7] = MODULUS_RESET;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset value of the modulus
        apb_access(1'b0, '0);

        // zero exponents, unit and full-scale bases, widest exponents
        push_job('0, '0);
        push_job('0, EXP_W'(1));
        push_job('0, EXP_MAX);
        push_job(WORD_W'(1), EXP_MAX);
        push_job({WORD_W{1'b1}}, '0);
        push_job({WORD_W{1'b1}}, EXP_W'(1));
        push_job({WORD_W{1'b1}}, EXP_MAX);
        push_job(MODULUS_RESET - 1, EXP_W'(2));
        push_job(MODULUS_RESET, EXP_W'(3));
        push_job(MODULUS_RESET + 1, EXP_MAX);
        push_job(WORD_W'(2), {1'b1, {(EXP_W-1){1'b0}}});
        push_job(WORD_W'(32'hAAAA_AAAA), EXP_W'(63'h2AAA_AAAA_AAAA_AAAA));
        push_job(WORD_W'(32'h5555_5555), EXP_W'(63'h5555_5555_5555_5555));
        // fermat check: a^(p-1) is one for the prime reset modulus
        push_job(WORD_W'(12345), EXP_W'(MODULUS_RESET - 1));
        queue_set(MODULUS_RESET, RANDOM_PER_SET);
        wait_idle();

        foreach (modulus_plan[i]) begin
            apb_access(1'b1, modulus_plan[i]);
            apb_access(1'b0, '0);
            queue_set(modulus_plan[i], RANDOM_PER_SET);
            wait_idle();
        end

        repeat (END_DRAIN) @(posedge i_clk);
        if (error_count == 0 && power_q.size() == 0) begin
            $display("modular_exponentiation regression: pass");
        end else begin
            $display("modular_exponentiation regression: fail");
        end
        $finish;
    end

endmodule
